// ===== hdl/playfair_cipher_encrypt_core_macros.svh =====
// assertion helpers for the playfair encrypt core
`ifndef PLAYFAIR_CIPHER_ENCRYPT_CORE_MACROS_SVH
`define PLAYFAIR_CIPHER_ENCRYPT_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define PF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("playfair core: assertion failed");

// next-cycle implication
`define PF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("playfair core: assertion failed");

`else

`define PF_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define PF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/pf_pkg.sv =====
package pf_pkg;

	localparam int SIDE = 5;
	localparam int CELLS = SIDE * SIDE;
	localparam int LETTER_W = 5;
	localparam int COORD_W = 3;
	localparam int SQUARE_W = CELLS * LETTER_W;

	localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
	localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
	localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 45;
	localparam int PART_A_W = 45;
	localparam int PART_BC_W = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_C = 2'd2;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [SQUARE_W-1:0] square_t;
	typedef logic [COORD_W-1:0] coord_t;

	typedef struct packed {
		letter_t first_letter;
		letter_t second_letter;
		logic    done;
	} pair_t;

	typedef struct packed {
		coord_t row;
		coord_t col;
	} pos_t;

	typedef struct packed {
		logic extra_pending;
	} front_status_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	typedef struct packed {
		logic second_half;
	} back_status_t;

	// step one row or column with wrap
	function automatic coord_t wrap_inc(input coord_t v);
		return (v == COORD_W'(SIDE - 1)) ? '0 : v + COORD_W'(1);
	endfunction

endpackage

// ===== hdl/pf_front.sv =====
module pf_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  pf_pkg::letter_t  in_letter,
	input  logic             in_end,
	output logic             push_valid,
	input  logic             push_ready,
	output pf_pkg::pair_t    push_pair,
	output pf_pkg::front_status_t status
);
	import pf_pkg::*;

	letter_t held_letter_q;
	logic    held_valid_q;
	pair_t   extra_pair_q;
	logic    extra_valid_q;

	letter_t letter;
	pair_t   pair0;
	pair_t   pair1;
	logic    has0;
	logic    has1;
	letter_t held_letter_d;
	logic    held_valid_d;
	logic    accept;

	always_comb begin
		letter = (in_letter == LETTER_J) ? LETTER_I : in_letter;
		pair0 = '0;
		pair1 = '0;
		has0 = 1'b0;
		has1 = 1'b0;
		held_letter_d = '0;
		held_valid_d = 1'b0;
		if (held_valid_q) begin
			has0 = 1'b1;
			if (letter == held_letter_q) begin
				// doubled letter: pad with x and carry the second one on
				pair0 = '{first_letter: held_letter_q, second_letter: LETTER_X, done: 1'b0};
				if (in_end) begin
					has1 = 1'b1;
					pair1 = '{first_letter: letter, second_letter: LETTER_X, done: 1'b1};
				end else begin
					held_letter_d = letter;
					held_valid_d = 1'b1;
				end
			end else begin
				pair0 = '{first_letter: held_letter_q, second_letter: letter, done: in_end};
			end
		end else if (in_end) begin
			has0 = 1'b1;
			pair0 = '{first_letter: letter, second_letter: LETTER_X, done: 1'b1};
		end else begin
			held_letter_d = letter;
			held_valid_d = 1'b1;
		end
	end

	assign in_ready = !extra_valid_q && push_ready;
	assign accept = in_valid && in_ready;
	assign push_valid = extra_valid_q || (accept && has0);
	assign push_pair = extra_valid_q ? extra_pair_q : pair0;
	assign status.extra_pending = extra_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q <= 1'b0;
			extra_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				held_letter_q <= held_letter_d;
				held_valid_q <= held_valid_d;
				extra_valid_q <= has1;
			end else if (extra_valid_q && push_ready) begin
				extra_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && has1) begin
			extra_pair_q <= pair1;
		end
	end

endmodule

// ===== hdl/pf_queue.sv =====
module pf_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  pf_pkg::pair_t push_pair,
	output logic          head_valid,
	output pf_pkg::pair_t head_pair,
	input  logic          pop,
	output pf_pkg::queue_status_t status
);
	import pf_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pair_t          entries_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           full;
	logic           empty;
	logic           do_push;
	logic           do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign push_ready = !full;
	assign head_valid = !empty;
	assign head_pair = entries_q[rd_ptr_q];
	assign do_push = push_valid && !full;
	assign do_pop = pop && !empty;
	assign status.full = full;
	assign status.empty = empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_pair;
		end
	end

endmodule

// ===== hdl/pf_back.sv =====
module pf_back (
	input  logic            clk,
	input  logic            arst_n,
	input  pf_pkg::square_t square,
	input  logic            head_valid,
	input  pf_pkg::pair_t   head_pair,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output pf_pkg::letter_t out_letter,
	output logic            out_done,
	output pf_pkg::back_status_t status
);
	import pf_pkg::*;

	// lowest matching cell wins, no match falls back to row 0 column 0
	function automatic pos_t find_pos(input square_t sq, input letter_t l);
		pos_t p;
		p = '0;
		for (int r = SIDE - 1; r >= 0; r--) begin
			for (int c = SIDE - 1; c >= 0; c--) begin
				if (sq[(r * SIDE + c) * LETTER_W +: LETTER_W] == l) begin
					p.row = COORD_W'(r);
					p.col = COORD_W'(c);
				end
			end
		end
		return p;
	endfunction

	function automatic letter_t pick_cell(input square_t sq, input pos_t p);
		letter_t v;
		v = '0;
		for (int r = 0; r < SIDE; r++) begin
			for (int c = 0; c < SIDE; c++) begin
				if (p.row == COORD_W'(r) && p.col == COORD_W'(c)) begin
					v = sq[(r * SIDE + c) * LETTER_W +: LETTER_W];
				end
			end
		end
		return v;
	endfunction

	// stage 1: pair taken from the queue
	logic    valid_s1;
	pair_t   pair_s1;
	// stage 2: square positions of both letters
	logic    valid_s2;
	pos_t    pos1_s2;
	pos_t    pos2_s2;
	logic    done_s2;
	// stage 3: cipher letters, sent one per transaction
	logic    valid_s3;
	letter_t letter1_s3;
	letter_t letter2_s3;
	logic    done_s3;
	logic    second_q;

	logic    adv1;
	logic    adv2;
	logic    drain3;
	pos_t    out1;
	pos_t    out2;

	assign drain3 = valid_s3 && second_q && out_ready;
	assign adv2 = valid_s2 && (!valid_s3 || drain3);
	assign adv1 = valid_s1 && (!valid_s2 || adv2);
	assign pop = head_valid && (!valid_s1 || adv1);

	always_comb begin
		if (pos1_s2.row == pos2_s2.row) begin
			out1 = '{row: pos1_s2.row, col: wrap_inc(pos1_s2.col)};
			out2 = '{row: pos2_s2.row, col: wrap_inc(pos2_s2.col)};
		end else if (pos1_s2.col == pos2_s2.col) begin
			out1 = '{row: wrap_inc(pos1_s2.row), col: pos1_s2.col};
			out2 = '{row: wrap_inc(pos2_s2.row), col: pos2_s2.col};
		end else begin
			out1 = '{row: pos1_s2.row, col: pos2_s2.col};
			out2 = '{row: pos2_s2.row, col: pos1_s2.col};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv1) begin
				valid_s2 <= 1'b1;
			end else if (adv2) begin
				valid_s2 <= 1'b0;
			end
			if (adv2) begin
				valid_s3 <= 1'b1;
				second_q <= 1'b0;
			end else if (valid_s3 && out_ready) begin
				if (second_q) begin
					valid_s3 <= 1'b0;
					second_q <= 1'b0;
				end else begin
					second_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pair_s1 <= head_pair;
		end
		if (adv1) begin
			pos1_s2 <= find_pos(square, pair_s1.first_letter);
			pos2_s2 <= find_pos(square, pair_s1.second_letter);
			done_s2 <= pair_s1.done;
		end
		if (adv2) begin
			letter1_s3 <= pick_cell(square, out1);
			letter2_s3 <= pick_cell(square, out2);
			done_s3 <= done_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_letter = second_q ? letter2_s3 : letter1_s3;
	assign out_done = second_q && done_s3;
	assign status.second_half = second_q;

endmodule

// ===== hdl/playfair_cipher_encrypt_core.sv =====
// path: the first cipher letter of a pair passes the pair queue and the pipeline stages of pf_back
// before it shows; the second letter follows once the first has been taken
// throughput: one input per cycle while the pair queue has room; an input that yields two
// pairs blocks input until its second pair is pushed; a pair leaves as two letter transactions
// reset: arst_n clears the held letter, the pair queue, the pipeline and the key square to zero
`include "playfair_cipher_encrypt_core_macros.svh"

module playfair_cipher_encrypt_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [4:0] plain_letter
	input  logic                          s_axis_tlast,  // text_end
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [7:0]                    m_axis_tdata,  // [4:0] cipher_letter
	output logic                          m_axis_tlast,  // message_done
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pf_pkg::*;

	logic [PART_A_W-1:0]  square_part_a_q;
	logic [PART_BC_W-1:0] square_part_b_q;
	logic [PART_BC_W-1:0] square_part_c_q;
	square_t              square;

	logic          push_valid;
	logic          push_ready;
	pair_t         push_pair;
	logic          head_valid;
	pair_t         head_pair;
	logic          pop;
	letter_t       out_letter;
	front_status_t front_st;
	queue_status_t queue_st;
	back_status_t  back_st;

	assign cfg_ready = 1'b1;
	assign square = {square_part_c_q, square_part_b_q, square_part_a_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			square_part_a_q <= '0;
			square_part_b_q <= '0;
			square_part_c_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SQUARE_A: square_part_a_q <= cfg_data[PART_A_W-1:0];
				CFG_SQUARE_B: square_part_b_q <= cfg_data[PART_BC_W-1:0];
				CFG_SQUARE_C: square_part_c_q <= cfg_data[PART_BC_W-1:0];
				default: ;
			endcase
		end
	end

	pf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_letter  (s_axis_tdata[LETTER_W-1:0]),
		.in_end     (s_axis_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_pair  (push_pair),
		.status     (front_st)
	);

	pf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_pair  (push_pair),
		.head_valid (head_valid),
		.head_pair  (head_pair),
		.pop        (pop),
		.status     (queue_st)
	);

	pf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.square     (square),
		.head_valid (head_valid),
		.head_pair  (head_pair),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_letter (out_letter),
		.out_done   (m_axis_tlast),
		.status     (back_st)
	);

	assign m_axis_tdata = {3'b000, out_letter};

	// no new input while the second pair of a split is still waiting
	`PF_ASSERT_NOW(a_extra_blocks_input, clk, arst_n, front_st.extra_pending, !s_axis_tready)
	// message end only ever rides on the second letter of a pair
	`PF_ASSERT_NOW(a_done_on_second, clk, arst_n, m_axis_tvalid && m_axis_tlast, back_st.second_half)
	`PF_ASSERT_NOW(a_queue_flags, clk, arst_n, queue_st.full, !queue_st.empty)
	// a delivered first letter is always followed by its partner
	`PF_ASSERT_NEXT(a_pair_completes, clk, arst_n,
		m_axis_tvalid && m_axis_tready && !back_st.second_half, m_axis_tvalid && back_st.second_half)

endmodule

// ===== tb/cipher_checker.sv =====
module cipher_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // [4:0] plain_letter
	input  logic                          s_axis_tlast,  // text_end
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [7:0]                    m_axis_tdata,  // [4:0] cipher_letter
	input  logic                          m_axis_tlast,  // message_done
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [pf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pf_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                            pending_results,
	output int                            fail_count,
	output int                            letters_checked
);
	import pf_pkg::*;

	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		letter_t letter;
		logic    done;
	} cipher_t;

	logic [PART_A_W-1:0]  part_a = '0;
	logic [PART_BC_W-1:0] part_b = '0;
	logic [PART_BC_W-1:0] part_c = '0;
	letter_t              held_letter = '0;
	logic                 held_valid = 1'b0;
	cipher_t              cipher_due [$];
	int                   mismatches = 0;
	int                   checked = 0;

	function automatic letter_t cell_at(input int k);
		logic [SQUARE_W-1:0] square;
		square = {part_c, part_b, part_a};
		return square[k*LETTER_W +: LETTER_W];
	endfunction

	// lowest matching cell wins, a missing letter sits at cell 0
	function automatic int cell_of(input letter_t letter);
		for (int k = 0; k < CELLS; k++)
			if (cell_at(k) == letter)
				return k;
		return 0;
	endfunction

	function automatic void encipher_pair(input letter_t first, input letter_t second,
			input logic done);
		int p1, p2, r1, c1, r2, c2, o1, o2;
		p1 = cell_of(first);
		p2 = cell_of(second);
		r1 = p1 / SIDE;
		c1 = p1 % SIDE;
		r2 = p2 / SIDE;
		c2 = p2 % SIDE;
		if (r1 == r2) begin
			o1 = r1 * SIDE + (c1 + 1) % SIDE;
			o2 = r2 * SIDE + (c2 + 1) % SIDE;
		end else if (c1 == c2) begin
			o1 = ((r1 + 1) % SIDE) * SIDE + c1;
			o2 = ((r2 + 1) % SIDE) * SIDE + c2;
		end else begin
			o1 = r1 * SIDE + c2;
			o2 = r2 * SIDE + c1;
		end
		cipher_due.push_back('{cell_at(o1), 1'b0});
		cipher_due.push_back('{cell_at(o2), done});
	endfunction

	function automatic void encipher_letter(input letter_t raw, input logic last);
		letter_t letter;
		letter = (raw == LETTER_J) ? LETTER_I : raw;
		if (held_valid && letter != held_letter) begin
			encipher_pair(held_letter, letter, last);
			held_valid = 1'b0;
			held_letter = '0;
			return;
		end
		// doubled letter: pad the held one with x, the new one stays held unless it ends the message
		if (held_valid)
			encipher_pair(held_letter, LETTER_X, 1'b0);
		if (last) begin
			encipher_pair(letter, LETTER_X, 1'b1);
			held_valid = 1'b0;
			held_letter = '0;
		end else begin
			held_letter = letter;
			held_valid = 1'b1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cipher_t got;
		cipher_t want;
		if (!arst_n) begin
			part_a = '0;
			part_b = '0;
			part_c = '0;
			held_letter = '0;
			held_valid = 1'b0;
			cipher_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SQUARE_A: part_a = cfg_data[PART_A_W-1:0];
					CFG_SQUARE_B: part_b = cfg_data[PART_BC_W-1:0];
					CFG_SQUARE_C: part_c = cfg_data[PART_BC_W-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				encipher_letter(s_axis_tdata[LETTER_W-1:0], s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata[LETTER_W-1:0], m_axis_tlast};
				if (cipher_due.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: cipher letter %0d last %0b with nothing expected",
							$time, got.letter, got.done);
				end else begin
					want = cipher_due.pop_front();
					checked++;
					if (got.letter !== want.letter) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: cipher_letter expected %0d got %0d",
								$time, want.letter, got.letter);
					end
					if (got.done !== want.done) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("%0t: message_done expected %0b got %0b",
								$time, want.done, got.done);
					end
				end
			end
		end
		pending_results <= cipher_due.size();
		fail_count <= mismatches;
		letters_checked <= checked;
	end

endmodule

// ===== tb/tb.sv =====
module tb;
	import pf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam int IDLE_PCT = 24;
	localparam int HOLD_CYCLES = 60;
	localparam int SETTLE_CYCLES = 12;
	localparam int PHASE_LETTERS = 22;

	typedef enum int {SQ_ALPHA, SQ_SHUFFLED, SQ_ONES, SQ_ZERO, SQ_NOISE} square_kind_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = '0;  // [4:0] plain_letter
	logic                  s_axis_tlast = 1'b0;  // text_end
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;  // [4:0] cipher_letter
	logic                  m_axis_tlast;  // message_done
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int      pending_results;
	int      fail_count;
	int      letters_checked;
	bit      steady = 1'b0;
	int      hold_req = 0;
	int      hold_done = 0;
	int      letters_sent = 0;
	int      squares_loaded = 0;
	letter_t prev_letter = '0;

	always #4 clk = ~clk;

	playfair_cipher_encrypt_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cipher_checker cipher_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tlast   (s_axis_tlast),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pending_results(pending_results),
		.fail_count     (fail_count),
		.letters_checked(letters_checked)
	);

	task automatic send_letter(input letter_t letter, input bit last);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, letter};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		letters_sent++;
		prev_letter = letter;
	endtask

	// stop offering and let every expected cipher letter come out
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_square(input square_kind_t kind);
		letter_t             cells [CELLS];
		logic [SQUARE_W-1:0] square;
		logic [4:0]          spare_bits;
		int                  pick;
		letter_t             swap;
		for (int k = 0; k < CELLS; k++) begin
			case (kind)
				SQ_ALPHA, SQ_SHUFFLED: cells[k] = letter_t'(k < 9 ? k : k + 1);
				SQ_ONES: cells[k] = '1;
				SQ_ZERO: cells[k] = '0;
				default: cells[k] = letter_t'($urandom_range(31));
			endcase
		end
		if (kind == SQ_SHUFFLED) begin
			for (int k = CELLS - 1; k > 0; k--) begin
				pick = $urandom_range(k);
				swap = cells[k];
				cells[k] = cells[pick];
				cells[pick] = swap;
			end
		end
		for (int k = 0; k < CELLS; k++)
			square[k*LETTER_W +: LETTER_W] = cells[k];
		// bits above the 40-bit parts must be dropped
		spare_bits = (kind == SQ_ONES) ? '1 : 5'($urandom);
		write_reg(CFG_SQUARE_A, square[PART_A_W-1:0]);
		write_reg(CFG_SQUARE_B, {spare_bits, square[PART_A_W +: PART_BC_W]});
		write_reg(CFG_SQUARE_C, {~spare_bits, square[PART_A_W+PART_BC_W +: PART_BC_W]});
		squares_loaded++;
	endtask

	task automatic send_message(input int length);
		letter_t letter;
		for (int n = 0; n < length; n++) begin
			case ($urandom_range(9))
				0, 1: letter = prev_letter;
				2: letter = LETTER_J;
				3: letter = LETTER_X;
				default: letter = letter_t'($urandom_range(25));
			endcase
			send_letter(letter, n == length - 1);
		end
	endtask

	// output side: random backpressure, or a long hold-off when asked
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_done != hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else begin
				m_axis_tready <= steady || $urandom_range(99) >= IDLE_PCT;
				@(posedge clk);
			end
		end
	end

	initial begin
		square_kind_t plan [5] = '{SQ_SHUFFLED, SQ_ONES, SQ_ZERO, SQ_NOISE, SQ_SHUFFLED};
		int           start;
		bit           paused;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// square still all zero: every letter falls back to cell 0
		send_letter(5'd0, 1'b0);
		send_letter(5'd25, 1'b0);
		send_letter(LETTER_X, 1'b1);
		drain();

		load_square(SQ_ALPHA);
		send_letter(5'd0, 1'b0);
		send_letter(5'd1, 1'b0);
		send_letter(5'd0, 1'b0);
		send_letter(5'd5, 1'b0);
		send_letter(5'd0, 1'b0);
		send_letter(5'd6, 1'b0);
		// j folds to i, so this doubles and then ends: two pairs at once
		send_letter(LETTER_J, 1'b0);
		send_letter(LETTER_I, 1'b1);
		send_letter(LETTER_X, 1'b1);
		send_letter(5'd25, 1'b0);
		send_letter(5'd25, 1'b0);
		send_letter(5'd24, 1'b1);
		send_letter(5'd2, 1'b1);
		send_letter(5'd3, 1'b0);
		send_letter(5'd7, 1'b0);
		send_letter(LETTER_J, 1'b1);
		// wrap along the last row and down the last column
		send_letter(5'd24, 1'b0);
		send_letter(5'd25, 1'b1);
		send_letter(5'd25, 1'b0);
		send_letter(5'd4, 1'b1);
		drain();

		write_reg(CFG_SPARE, CFG_DATA_W'({$urandom, $urandom}));

		foreach (plan[ph]) begin
			load_square(plan[ph]);
			if (ph == 0)
				hold_req++;
			if (ph == 4)
				steady = 1'b1;
			start = letters_sent;
			paused = 1'b0;
			while (letters_sent - start < PHASE_LETTERS) begin
				if (ph == 3 && !paused && letters_sent - start >= PHASE_LETTERS / 2) begin
					drain();
					paused = 1'b1;
				end
				send_message($urandom_range(1, 8));
			end
			drain();
			steady = 1'b0;
		end

		$display("tb: %0d plaintext letters under %0d key squares, %0d cipher letters checked",
			letters_sent, squares_loaded, letters_checked);
		$display("tb: j folding, doubled letters, x padding, missing letters, output hold-off");
		if (fail_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
